[src/oahp_pkg.sv]
// ----------------------------------------------------------------------------
// oahp_pkg
// Shared types and constants of the hash table probe engine: geometry,
// command and mark codes, result kinds, and the controller/datapath buses.
// ----------------------------------------------------------------------------
package oahp_pkg;

    // table geometry
    localparam int SLOTS      = 256;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CAP_W      = SLOT_W + 1;
    localparam int KEY_BYTES  = 8;
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int VALUE_BITS = 32;
    localparam int BCNT_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    // ELF hash: running hash fits in 36 bits, top nibble folds down by 24
    localparam int HASH_W     = 36;
    localparam int FOLD_SHIFT = 24;
    localparam int MCNT_W     = $clog2(HASH_W);

    // command codes
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_FIRST  = 2'd2;
    localparam logic [1:0] CMD_NEXT   = 2'd3;

    // slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_TOMB  = 2'd1;
    localparam logic [1:0] MARK_OCC   = 2'd2;

    // result kinds
    localparam logic [2:0] RES_NONE       = 3'd0;
    localparam logic [2:0] RES_WRITE      = 3'd1;
    localparam logic [2:0] RES_HIT        = 3'd2;
    localparam logic [2:0] RES_MISS_HERE  = 3'd3;
    localparam logic [2:0] RES_MISS_START = 3'd4;
    localparam logic [2:0] RES_SCAN_HIT   = 3'd5;

    typedef struct packed {
        logic       ld;
        logic       hash_init;
        logic       hash_step;
        logic       mod_init;
        logic       mod_step;
        logic       probe_init;
        logic       probe_adv;
        logic       scan_zero;
        logic       scan_next;
        logic       scan_adv;
        logic       rd_idx;
        logic       rd_sidx;
        logic       wr;
        logic       res_set;
        logic [2:0] res_kind;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       bad_write;
        logic       count_zero;
        logic       hash_last;
        logic       mod_last;
        logic       m_empty;
        logic       m_occ;
        logic       key_match;
        logic       probe_last;
        logic       scan_last;
        logic       next_none;
        logic       out_free;
    } t_dp_stat;

endpackage

[src/oahp_ctrl.sv]
// ----------------------------------------------------------------------------
// oahp_ctrl
// Sequencer of the probe engine: decodes a command, steps the hash and the
// modulo, walks the probe and the scans, and hands the result to the output.
// ----------------------------------------------------------------------------
module oahp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  oahp_pkg::t_dp_stat  i_stat,
    output oahp_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_WWR  = 4'd2;
    localparam logic [3:0] S_HASH = 4'd3;
    localparam logic [3:0] S_MINI = 4'd4;
    localparam logic [3:0] S_MOD  = 4'd5;
    localparam logic [3:0] S_PINI = 4'd6;
    localparam logic [3:0] S_PRD  = 4'd7;
    localparam logic [3:0] S_PEV  = 4'd8;
    localparam logic [3:0] S_SRD  = 4'd9;
    localparam logic [3:0] S_SEV  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.cmd == oahp_pkg::CMD_WRITE) begin
                    if (i_stat.bad_write) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = oahp_pkg::RES_WRITE;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.rd_sidx = 1'b1;
                        n_state       = S_WWR;
                    end
                end else if (i_stat.count_zero) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = oahp_pkg::RES_NONE;
                    n_state        = S_OUT;
                end else if (i_stat.cmd == oahp_pkg::CMD_FIRST) begin
                    o_cmd.scan_zero = 1'b1;
                    n_state         = S_SRD;
                end else begin
                    o_cmd.hash_init = 1'b1;
                    n_state         = S_HASH;
                end
            end
            S_WWR: begin
                o_cmd.wr       = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = oahp_pkg::RES_WRITE;
                n_state        = S_OUT;
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_MINI;
                end
            end
            S_MINI: begin
                o_cmd.mod_init = 1'b1;
                n_state        = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_PINI;
                end
            end
            S_PINI: begin
                o_cmd.probe_init = 1'b1;
                n_state          = S_PRD;
            end
            S_PRD: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_PEV;
            end
            S_PEV: begin
                if (i_stat.m_empty) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = (i_stat.cmd == oahp_pkg::CMD_LOOKUP) ?
                                     oahp_pkg::RES_MISS_HERE : oahp_pkg::RES_NONE;
                    n_state        = S_OUT;
                end else if (i_stat.m_occ && i_stat.key_match) begin
                    if (i_stat.cmd == oahp_pkg::CMD_LOOKUP) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = oahp_pkg::RES_HIT;
                        n_state        = S_OUT;
                    end else if (i_stat.next_none) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = oahp_pkg::RES_NONE;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state         = S_SRD;
                    end
                end else if (i_stat.probe_last) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = (i_stat.cmd == oahp_pkg::CMD_LOOKUP) ?
                                     oahp_pkg::RES_MISS_START : oahp_pkg::RES_NONE;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.probe_adv = 1'b1;
                    n_state         = S_PRD;
                end
            end
            S_SRD: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_SEV;
            end
            S_SEV: begin
                if (i_stat.m_occ) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = oahp_pkg::RES_SCAN_HIT;
                    n_state        = S_OUT;
                end else if (i_stat.scan_last) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = oahp_pkg::RES_NONE;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_SRD;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/oahp_dp.sv]
// ----------------------------------------------------------------------------
// oahp_dp
// Datapath of the probe engine: command registers, byte-serial ELF hash,
// bit-serial modulo, slot store with valid bits, probe and scan index,
// occupied count, capacity register and the result/output registers.
// ----------------------------------------------------------------------------
module oahp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  oahp_pkg::t_dp_cmd                   i_cmd,
    output oahp_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_we,
    input  logic [oahp_pkg::CAP_W-1:0]          i_cfg_cap,
    input  logic [1:0]                          i_op,
    input  logic [7:0]                          i_slot_index,
    input  logic [oahp_pkg::KEY_W-1:0]          i_key,
    input  logic [oahp_pkg::VALUE_BITS-1:0]     i_entry_value,
    input  logic [1:0]                          i_entry_mark,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_found,
    output logic [oahp_pkg::KEY_W-1:0]          o_key_out,
    output logic [oahp_pkg::VALUE_BITS-1:0]     o_value_out,
    output logic [7:0]                          o_slot_out
);

    localparam int SW = oahp_pkg::SLOT_W;
    localparam int CW = oahp_pkg::CAP_W;
    localparam int KW = oahp_pkg::KEY_W;
    localparam int VW = oahp_pkg::VALUE_BITS;
    localparam int HW = oahp_pkg::HASH_W;
    localparam int MW = 2 + KW + VW;

    // command registers
    logic [1:0]    r_op;
    logic [7:0]    r_sidx;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [1:0]    r_mark;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_op   <= i_op;
            r_sidx <= i_slot_index;
            r_key  <= i_key;
            r_val  <= i_entry_value;
            r_mark <= i_entry_mark;
        end
    end

    // capacity register, effective capacity clamped to 1..SLOTS
    logic [CW-1:0] r_cap_raw;
    logic [CW-1:0] cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_raw <= CW'(oahp_pkg::SLOTS);
        end else if (i_cfg_we) begin
            r_cap_raw <= i_cfg_cap;
        end
    end

    always_comb begin
        if (r_cap_raw == '0) begin
            cap = CW'(1);
        end else if (r_cap_raw > CW'(oahp_pkg::SLOTS)) begin
            cap = CW'(oahp_pkg::SLOTS);
        end else begin
            cap = r_cap_raw;
        end
    end

    // ELF hash, one key byte a step
    logic [HW-1:0]               r_h;
    logic [oahp_pkg::BCNT_W-1:0] r_bcnt;
    logic [HW+3:0]               h_sum;
    logic [3:0]                  h_top;
    logic [HW-1:0]               n_h;

    always_comb begin
        h_sum = {r_h, 4'b0000} + (HW+4)'(r_key[8*r_bcnt +: 8]);
        h_top = h_sum[HW+3:HW];
        n_h   = h_sum[HW-1:0] ^ (HW'(h_top) << (HW - oahp_pkg::FOLD_SHIFT));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_init) begin
            r_h    <= '0;
            r_bcnt <= '0;
        end else if (i_cmd.hash_step) begin
            r_h    <= n_h;
            r_bcnt <= r_bcnt + 1'b1;
        end
    end

    // hash modulo capacity, one dividend bit a step
    logic [HW-1:0]                r_dv;
    logic [CW-1:0]                r_rem;
    logic [oahp_pkg::MCNT_W-1:0]  r_mcnt;
    logic [CW:0]                  m_try;
    logic [CW-1:0]                n_rem;

    always_comb begin
        m_try = {r_rem, r_dv[HW-1]};
        if (m_try >= {1'b0, cap}) begin
            m_try = m_try - {1'b0, cap};
        end
        n_rem = m_try[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_init) begin
            r_dv   <= r_h;
            r_rem  <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_dv   <= r_dv << 1;
            r_rem  <= n_rem;
            r_mcnt <= r_mcnt + 1'b1;
        end
    end

    // probe and scan index
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_start;
    logic [CW-1:0] r_n;
    logic [CW-1:0] idx_inc;

    assign idx_inc = {1'b0, r_idx} + CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_idx   <= r_rem[SW-1:0];
            r_start <= r_rem[SW-1:0];
            r_n     <= '0;
        end else if (i_cmd.probe_adv) begin
            r_idx <= (idx_inc >= cap) ? '0 : idx_inc[SW-1:0];
            r_n   <= r_n + 1'b1;
        end else if (i_cmd.scan_zero) begin
            r_idx <= '0;
        end else if (i_cmd.scan_next || i_cmd.scan_adv) begin
            r_idx <= idx_inc[SW-1:0];
        end
    end

    // slot store: mark, key and value in one word; valid bits say written
    logic [MW-1:0]    mem [oahp_pkg::SLOTS];
    logic [MW-1:0]    r_rdata;
    logic             r_rd_vld;
    logic [SW-1:0]    rd_addr;
    logic             slot_written [oahp_pkg::SLOTS];
    logic [SW-1:0]    wr_addr;
    logic [1:0]       rd_mark;
    logic [KW-1:0]    rd_key;
    logic [VW-1:0]    rd_val;

    assign rd_addr = i_cmd.rd_sidx ? r_sidx[SW-1:0] : r_idx;
    assign wr_addr = r_sidx[SW-1:0];
    assign rd_mark = r_rd_vld ? r_rdata[MW-1 -: 2] : oahp_pkg::MARK_EMPTY;
    assign rd_key  = r_rdata[KW+VW-1:VW];
    assign rd_val  = r_rdata[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[wr_addr] <= {r_mark, r_key, r_val};
        end
        if (i_cmd.rd_idx || i_cmd.rd_sidx) begin
            r_rdata  <= mem[rd_addr];
            r_rd_vld <= slot_written[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < oahp_pkg::SLOTS; i++) begin
                slot_written[i] <= 1'b0;
            end
        end else if (i_cmd.wr) begin
            slot_written[wr_addr] <= 1'b1;
        end
    end

    // occupied count follows the change of the written slot's mark
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr) begin
            if (rd_mark == oahp_pkg::MARK_OCC && r_mark != oahp_pkg::MARK_OCC
                && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end else if (rd_mark != oahp_pkg::MARK_OCC && r_mark == oahp_pkg::MARK_OCC) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // pending result
    logic          r_res_found;
    logic [KW-1:0] r_res_key;
    logic [VW-1:0] r_res_val;
    logic [7:0]    r_res_slot;
    logic          bad_write;

    assign bad_write = (r_mark == 2'd3) || ({1'b0, r_sidx} >= 9'(oahp_pkg::SLOTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            case (i_cmd.res_kind)
                oahp_pkg::RES_WRITE: begin
                    r_res_found <= !bad_write;
                    r_res_key   <= '0;
                    r_res_val   <= '0;
                    r_res_slot  <= r_sidx;
                end
                oahp_pkg::RES_HIT: begin
                    r_res_found <= 1'b1;
                    r_res_key   <= rd_key;
                    r_res_val   <= rd_val;
                    r_res_slot  <= 8'(r_idx);
                end
                oahp_pkg::RES_MISS_HERE: begin
                    r_res_found <= 1'b0;
                    r_res_key   <= '0;
                    r_res_val   <= '0;
                    r_res_slot  <= 8'(r_idx);
                end
                oahp_pkg::RES_MISS_START: begin
                    r_res_found <= 1'b0;
                    r_res_key   <= '0;
                    r_res_val   <= '0;
                    r_res_slot  <= 8'(r_start);
                end
                oahp_pkg::RES_SCAN_HIT: begin
                    r_res_found <= 1'b1;
                    r_res_key   <= rd_key;
                    r_res_val   <= '0;
                    r_res_slot  <= 8'(r_idx);
                end
                default: begin
                    r_res_found <= 1'b0;
                    r_res_key   <= '0;
                    r_res_val   <= '0;
                    r_res_slot  <= '0;
                end
            endcase
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_found     <= r_res_found;
            o_key_out   <= r_res_key;
            o_value_out <= r_res_val;
            o_slot_out  <= r_res_slot;
        end
    end

    assign o_out_valid = r_out_valid;

    // status to the controller
    always_comb begin
        o_stat.cmd        = r_op;
        o_stat.bad_write  = bad_write;
        o_stat.count_zero = (r_count == '0);
        o_stat.hash_last  = (r_bcnt == oahp_pkg::BCNT_W'(oahp_pkg::KEY_BYTES - 1));
        o_stat.mod_last   = (r_mcnt == oahp_pkg::MCNT_W'(HW - 1));
        o_stat.m_empty    = (rd_mark == oahp_pkg::MARK_EMPTY);
        o_stat.m_occ      = (rd_mark == oahp_pkg::MARK_OCC);
        o_stat.key_match  = (rd_key == r_key);
        o_stat.probe_last = ((r_n + 1'b1) == cap);
        o_stat.scan_last  = (idx_inc >= cap);
        o_stat.next_none  = (idx_inc >= cap);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

[src/open_address_hash_table_probe_top.sv]
// ----------------------------------------------------------------------------
// open_address_hash_table_probe_top
// Open-addressed hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// One word in gives one word out. A slot write reads the old mark of its slot, then
// writes the slot; a lookup or a next-key command runs the byte-serial ELF hash, then
// the bit-serial modulo, then reads and checks one probed slot after another (one slot
// store read port, registered), and next-key then scans on slot by slot; first-key
// scans slot by slot from slot zero. With an empty table lookup, first and next answer
// without hashing or scanning. One command is worked at a time; a new word is taken
// while the previous result still waits at the output. Slot marks reset to empty at
// once through per-slot valid bits, so no clearing pass is needed.
module open_address_hash_table_probe_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot_index[7:0], key[71:8], entry_value[103:72], entry_mark[105:104], zeros
    input  logic [111:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // key_out[63:0], value_out[95:64], slot_out[103:96]
    output logic [103:0] m_axis_tdata,
    // found[0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [8:0]   i_cfg_data
);

    oahp_pkg::t_dp_cmd  dp_cmd;
    oahp_pkg::t_dp_stat dp_stat;
    logic [63:0]        key_out;
    logic [31:0]        value_out;
    logic [7:0]         slot_out;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {slot_out, value_out, key_out};

    oahp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    oahp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_cap     (i_cfg_data),
        .i_op          (s_axis_tuser),
        .i_slot_index  (s_axis_tdata[7:0]),
        .i_key         (s_axis_tdata[71:8]),
        .i_entry_value (s_axis_tdata[103:72]),
        .i_entry_mark  (s_axis_tdata[105:104]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_found       (m_axis_tuser),
        .o_key_out     (key_out),
        .o_value_out   (value_out),
        .o_slot_out    (slot_out)
    );

endmodule

[verif/open_address_hash_table_probe_top_test.sv]
// ----------------------------------------------------------------------------
// open_address_hash_table_probe_top_test
// Self-checking bench for the hash table probe engine. A behavioural table
// (ELF hash, linear probing, tombstones) predicts each result word; every
// output word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module open_address_hash_table_probe_top_test;

    typedef struct packed {
        logic        found;
        logic [63:0] key_out;
        logic [31:0] value_out;
        logic [7:0]  slot_out;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [8:0]   i_cfg_data;

    // shadow table
    logic [63:0] tbl_key [oahp_pkg::SLOTS];
    logic [31:0] tbl_val [oahp_pkg::SLOTS];
    logic [1:0]  tbl_mark [oahp_pkg::SLOTS];
    int          occ_count;
    int          capacity;

    t_answer     answers_due[$];
    int          errors;
    int          answers_seen;
    longint      cycles;
    int          stall_pct;
    logic [63:0] known_keys[$];

    open_address_hash_table_probe_top u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard limit on run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd10000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [38:0] fold_hash(input logic [63:0] k);
        logic [63:0] h;
        logic [63:0] top;
        h = '0;
        for (int i = 0; i < oahp_pkg::KEY_BYTES; i++) begin
            h = (h << 4) + 64'(k[8*i +: 8]);
            top = h & 64'hF000000000;
            if (top != 0) begin
                h = h ^ (top >> 24);
                h = h & ~top;
            end
        end
        return h[38:0];
    endfunction

    function automatic int cap_eff();
        if (capacity < 1) return 1;
        if (capacity > oahp_pkg::SLOTS) return oahp_pkg::SLOTS;
        return capacity;
    endfunction

    // probe for a key; slot holds the stopping or matching slot
    function automatic bit probe_key(input logic [63:0] k, output int slot);
        int cap;
        int start;
        int idx;
        cap = cap_eff();
        start = int'(64'(fold_hash(k)) % 64'(cap));
        idx = start;
        for (int n = 0; n < cap; n++) begin
            if (tbl_mark[idx] == oahp_pkg::MARK_EMPTY) begin
                slot = idx;
                return 0;
            end
            if (tbl_mark[idx] == oahp_pkg::MARK_OCC && tbl_key[idx] == k) begin
                slot = idx;
                return 1;
            end
            idx = (idx + 1 >= cap) ? 0 : idx + 1;
        end
        slot = start;
        return 0;
    endfunction

    function automatic t_answer predict_answer(input logic [1:0] cmd, input logic [7:0] sidx,
                                               input logic [63:0] k, input logic [31:0] v,
                                               input logic [1:0] mark);
        t_answer a;
        int s;
        int cap;
        a = '0;
        cap = cap_eff();
        if (cmd == oahp_pkg::CMD_WRITE) begin
            a.slot_out = sidx;
            if (mark <= oahp_pkg::MARK_OCC) begin
                if (tbl_mark[sidx] == oahp_pkg::MARK_OCC && mark != oahp_pkg::MARK_OCC
                    && occ_count > 0)
                    occ_count--;
                if (tbl_mark[sidx] != oahp_pkg::MARK_OCC && mark == oahp_pkg::MARK_OCC)
                    occ_count++;
                tbl_mark[sidx] = mark;
                tbl_key[sidx] = k;
                tbl_val[sidx] = v;
                a.found = 1'b1;
            end
        end else if (occ_count != 0) begin
            if (cmd == oahp_pkg::CMD_LOOKUP) begin
                if (probe_key(k, s)) begin
                    a.found = 1'b1;
                    a.key_out = tbl_key[s];
                    a.value_out = tbl_val[s];
                end
                a.slot_out = 8'(s);
            end else if (cmd == oahp_pkg::CMD_FIRST) begin
                for (int i = 0; i < cap; i++) begin
                    if (tbl_mark[i] == oahp_pkg::MARK_OCC) begin
                        a.found = 1'b1;
                        a.key_out = tbl_key[i];
                        a.slot_out = 8'(i);
                        break;
                    end
                end
            end else if (probe_key(k, s)) begin
                for (int i = s + 1; i < cap; i++) begin
                    if (tbl_mark[i] == oahp_pkg::MARK_OCC) begin
                        a.found = 1'b1;
                        a.key_out = tbl_key[i];
                        a.slot_out = 8'(i);
                        break;
                    end
                end
            end
        end
        return a;
    endfunction

    // drop valid for a random gap
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 99) < 50) ? 0 :
            ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // send one command word and record its prediction
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] sidx,
                             input logic [63:0] k, input logic [31:0] v,
                             input logic [1:0] mark);
        if (stall_pct > 0) idle_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, mark, v, k, sidx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        answers_due.push_back(predict_answer(cmd, sidx, k, v, mark));
        if (cmd == oahp_pkg::CMD_WRITE && mark == oahp_pkg::MARK_OCC) known_keys.push_back(k);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic set_capacity(input int c);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= 9'(c);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        capacity = c;
    endtask

    // result checker with random back-pressure
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[95:64],
                       m_axis_tdata[103:96]};
                if (answers_due.size() == 0) begin
                    $error("result word with no prediction waiting");
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    answers_seen++;
                    if (got.found !== want.found) begin
                        $error("found exp %0h got %0h", want.found, got.found);
                        errors++;
                    end
                    if (got.key_out !== want.key_out) begin
                        $error("key_out exp %0h got %0h", want.key_out, got.key_out);
                        errors++;
                    end
                    if (got.value_out !== want.value_out) begin
                        $error("value_out exp %0h got %0h", want.value_out, got.value_out);
                        errors++;
                    end
                    if (got.slot_out !== want.slot_out) begin
                        $error("slot_out exp %0h got %0h", want.slot_out, got.slot_out);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct) ||
                             ($urandom_range(0, 199) == 0);
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // edge cases on an empty then lightly filled table
    task automatic test_directed();
        int s;
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, 64'h1234, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_FIRST, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_NEXT, 8'd0, 64'd5, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_WRITE, 8'd255, '1, '1, oahp_pkg::MARK_OCC);
        send_word(oahp_pkg::CMD_WRITE, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_OCC);
        send_word(oahp_pkg::CMD_WRITE, 8'd7, 64'h55, 32'd9, 2'd3);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, '1, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, 64'hDEAD, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_FIRST, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_NEXT, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_NEXT, 8'd0, '1, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_NEXT, 8'd0, 64'hBEEF, 32'd0, oahp_pkg::MARK_EMPTY);
        // tombstone in a probe chain
        s = int'(64'(fold_hash(64'hABCDEF)) % 64'(cap_eff()));
        send_word(oahp_pkg::CMD_WRITE, 8'(s), 64'h1, 32'd1, oahp_pkg::MARK_TOMB);
        send_word(oahp_pkg::CMD_WRITE, 8'((s + 1) % 256), 64'hABCDEF, 32'h77,
                  oahp_pkg::MARK_OCC);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, 64'hABCDEF, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_WRITE, 8'((s + 1) % 256), 64'hABCDEF, 32'h77,
                  oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, 64'hABCDEF, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_WRITE, 8'd255, '1, '1, oahp_pkg::MARK_TOMB);
        send_word(oahp_pkg::CMD_WRITE, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_EMPTY);
    endtask

    // fill a small table completely so probes wrap and run out
    task automatic test_full_table();
        set_capacity(4);
        for (int i = 0; i < 4; i++)
            send_word(oahp_pkg::CMD_WRITE, 8'(i), rand_key(), $urandom(), oahp_pkg::MARK_OCC);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, rand_key(), 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, known_keys[known_keys.size() - 1], 32'd0,
                  oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_FIRST, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_NEXT, 8'd0, known_keys[known_keys.size() - 4], 32'd0,
                  oahp_pkg::MARK_EMPTY);
        set_capacity(0);
        send_word(oahp_pkg::CMD_LOOKUP, 8'd0, rand_key(), 32'd0, oahp_pkg::MARK_EMPTY);
        send_word(oahp_pkg::CMD_FIRST, 8'd0, 64'd0, 32'd0, oahp_pkg::MARK_EMPTY);
    endtask

    // random mix, keys mostly drawn from those already written
    task automatic test_random(input int count, input int slot_hi);
        logic [1:0]  cmd;
        logic [63:0] k;
        logic [7:0]  sidx;
        int          r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            cmd = (r < 35) ? oahp_pkg::CMD_WRITE : (r < 70) ? oahp_pkg::CMD_LOOKUP :
                  (r < 80) ? oahp_pkg::CMD_FIRST : oahp_pkg::CMD_NEXT;
            if (known_keys.size() != 0 && $urandom_range(0, 99) < 60)
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else if ($urandom_range(0, 3) == 0)
                k = 64'($urandom_range(0, 255));
            else
                k = rand_key();
            sidx = ($urandom_range(0, 9) == 0) ? 8'($urandom()) :
                   8'($urandom_range(0, slot_hi));
            r = $urandom_range(0, 99);
            send_word(cmd, sidx, k, $urandom(),
                      (r < 60) ? oahp_pkg::MARK_OCC : (r < 80) ? oahp_pkg::MARK_TOMB :
                      (r < 95) ? oahp_pkg::MARK_EMPTY : 2'd3);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        errors = 0;
        answers_seen = 0;
        cycles = 0;
        stall_pct = 0;
        capacity = 256;
        occ_count = 0;
        for (int i = 0; i < oahp_pkg::SLOTS; i++) tbl_mark[i] = oahp_pkg::MARK_EMPTY;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        stall_pct = 30;
        test_full_table();
        set_capacity(256);
        test_random(500, 255);
        set_capacity(37);
        test_random(400, 40);
        set_capacity(1);
        test_random(100, 3);
        set_capacity(300);
        test_random(350, 255);
        // hold off until the pipeline is empty, then carry on without gaps
        drain();
        stall_pct = 0;
        test_random(200, 255);
        stall_pct = 30;
        set_capacity(16);
        test_random(200, 20);
        drain();

        $display("Covered %0d result words over capacities 0, 1, 4, 16, 37, 256, 300,",
                 answers_seen);
        $display("with writes, lookups, first/next scans, tombstones and full-table probes.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
